FILE: src/button_debounce_autorepeat_assert.svh
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// same-cycle implication
`define BDA_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bda_pkg.sv
package bda_pkg;

  localparam int STAMP_W     = 32;
  localparam int MS_W        = 16;
  localparam int US_W        = 26;
  localparam int TALLY_W     = 16;
  localparam int US_PER_MS   = 1000;
  localparam int WRAP_LIMIT  = 64;
  localparam int CFG_INDEX_W = 2;

  localparam int CMD_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF = 2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd3;

  typedef struct packed {
    logic               pin_level;
    logic [STAMP_W-1:0] now_us;
    logic               take_repeats;
  } in_t;

  typedef struct packed {
    logic               went_down;
    logic               went_up;
    logic               held;
    logic [STAMP_W-1:0] last_press_us;
    logic [STAMP_W-1:0] current_press_us;
    logic [TALLY_W-1:0] repeat_total;
  } out_t;

  // classified poll
  typedef struct packed {
    logic               pressed;
    logic [STAMP_W-1:0] now_us;
    logic               take;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [STAMP_W-1:0] dividend;
    logic [US_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [STAMP_W-1:0] quotient;
    logic [US_W-1:0]    remainder;
  } div_rsp_t;

endpackage

FILE: src/bda_front.sv
module bda_front #(
  parameter int DEPTH = bda_pkg::CMD_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  bda_pkg::in_t item,
  input  logic         invert,
  output logic         cmd_valid,
  output bda_pkg::cmd_t cmd,
  input  logic         cmd_pop
);
  import bda_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;
  cmd_t             entry;

  assign full      = (count == CNT_W'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // pressed is the pin level seen through the polarity setting
  always_comb begin
    entry.pressed = item.pin_level ^ invert;
    entry.now_us  = item.now_us;
    entry.take    = item.take_repeats;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/bda_div.sv
module bda_div (
  input  logic              clk,
  input  logic              rst,
  input  bda_pkg::div_req_t req,
  output bda_pkg::div_rsp_t rsp
);
  import bda_pkg::*;

  localparam int CNT_W = $clog2(STAMP_W);

  logic [STAMP_W-1:0] quo;
  logic [US_W-1:0]    rem;
  logic [US_W-1:0]    dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [US_W:0]      cand;
  logic               ge;
  logic [US_W:0]      diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    cand = {rem, quo[STAMP_W-1]};
    ge   = (cand >= {1'b0, dvs});
    diff = cand - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[STAMP_W-2:0], ge};
      rem <= ge ? diff[US_W-1:0] : cand[US_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STAMP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.busy      = busy;
    rsp.done      = done;
    rsp.quotient  = quo;
    rsp.remainder = rem;
  end

endmodule

FILE: src/bda_back.sv
`include "button_debounce_autorepeat_assert.svh"

module bda_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  input  bda_pkg::cmd_t            cmd,
  output logic                     cmd_pop,
  input  logic [bda_pkg::US_W-1:0] debounce_us,
  input  logic [bda_pkg::US_W-1:0] delay_us,
  input  logic [bda_pkg::US_W-1:0] step_us,
  output logic                     res_push,
  output bda_pkg::out_t            res,
  input  logic                     res_full
);
  import bda_pkg::*;

  localparam logic [1:0] MODE_RELEASED = 2'd0;
  localparam logic [1:0] MODE_DEBOUNCE = 2'd1;
  localparam logic [1:0] MODE_PRESSED  = 2'd2;
  localparam logic [1:0] MODE_REPEAT   = 2'd3;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CU_SUM = 3'd2;
  localparam logic [2:0] S_CU_CMP = 3'd3;
  localparam logic [2:0] S_CU_DIV = 3'd4;
  localparam logic [2:0] S_HOLD   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  localparam int WRAP_W = $clog2(WRAP_LIMIT);

  logic [2:0]         state;
  logic [1:0]         mode;
  logic [STAMP_W-1:0] start_stamp;
  logic [STAMP_W-1:0] last_len;
  logic [STAMP_W-1:0] last_rep;
  logic [TALLY_W-1:0] tally;
  cmd_t               cur;
  logic               down;
  logic               up;
  logic               held;
  logic [WRAP_W-1:0]  wraps;
  logic [STAMP_W-1:0] s_sum;

  logic [STAMP_W-1:0] deb_end;
  logic [STAMP_W-1:0] delay_end;
  logic [STAMP_W:0]   tally_sum;
  logic [TALLY_W-1:0] tally_sat;
  logic [TALLY_W-1:0] tally_inc;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  bda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign deb_end   = start_stamp + STAMP_W'(debounce_us);
  assign delay_end = start_stamp + STAMP_W'(delay_us);
  assign tally_sum = (STAMP_W+1)'(div_rsp.quotient) + (STAMP_W+1)'(tally)
                   + (STAMP_W+1)'(1);
  assign tally_sat = (tally_sum > (STAMP_W+1)'(TALLY_MAX)) ? TALLY_MAX
                                                           : tally_sum[TALLY_W-1:0];
  assign tally_inc = (tally == TALLY_MAX) ? TALLY_MAX : tally + TALLY_W'(1);

  assign cmd_pop  = (state == S_IDLE) && cmd_valid && !res_full;
  assign res_push = (state == S_FINISH);

  // repeats still owed: divide the gap to now by the interval
  always_comb begin
    div_req.start    = (state == S_CU_CMP) && (s_sum < cur.now_us);
    div_req.dividend = cur.now_us - s_sum - STAMP_W'(1);
    div_req.divisor  = step_us;
  end

  always_comb begin
    res.went_down        = down;
    res.went_up          = up;
    res.held             = held;
    res.last_press_us    = last_len;
    res.current_press_us = cur.now_us - start_stamp;
    res.repeat_total     = cur.take ? tally : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == S_CU_SUM) begin
      s_sum <= last_rep + STAMP_W'(step_us);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= MODE_RELEASED;
      start_stamp <= '0;
      last_len    <= '0;
      last_rep    <= '0;
      tally       <= '0;
      down        <= 1'b0;
      up          <= 1'b0;
      held        <= 1'b0;
      wraps       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            down  <= 1'b0;
            up    <= 1'b0;
            held  <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (mode) inside
            MODE_RELEASED: begin
              if (cur.pressed) begin
                mode        <= MODE_DEBOUNCE;
                start_stamp <= cur.now_us;
              end
              state <= S_FINISH;
            end
            MODE_DEBOUNCE: begin
              if (cur.pressed) begin
                if (cur.now_us >= deb_end) begin
                  down        <= 1'b1;
                  mode        <= MODE_PRESSED;
                  start_stamp <= cur.now_us;
                  tally       <= TALLY_W'(1);
                end
              end else begin
                mode <= MODE_RELEASED;
              end
              state <= S_FINISH;
            end
            MODE_PRESSED, MODE_REPEAT: begin
              wraps <= '0;
              if (mode == MODE_REPEAT && step_us != '0) begin
                state <= S_CU_SUM;
              end else begin
                state <= S_HOLD;
              end
            end
            default: state <= S_FINISH;
          endcase
        end
        S_CU_SUM: begin
          state <= S_CU_CMP;
        end
        S_CU_CMP: begin
          state <= div_req.start ? S_CU_DIV : S_HOLD;
        end
        S_CU_DIV: begin
          if (div_rsp.done) begin
            tally    <= tally_sat;
            last_rep <= cur.now_us - STAMP_W'(1) - STAMP_W'(div_rsp.remainder);
            if (wraps == WRAP_W'(WRAP_LIMIT - 1)) begin
              state <= S_HOLD;
            end else begin
              wraps <= wraps + WRAP_W'(1);
              state <= S_CU_SUM;
            end
          end
        end
        S_HOLD: begin
          held <= cur.pressed;
          if (cur.pressed) begin
            if (mode == MODE_PRESSED && delay_us != '0 && cur.now_us >= delay_end) begin
              mode     <= MODE_REPEAT;
              last_rep <= cur.now_us;
              tally    <= tally_inc;
            end
          end else begin
            up       <= 1'b1;
            mode     <= MODE_RELEASED;
            last_len <= cur.now_us - start_stamp;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (cur.take) begin
            tally <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BDA_ASSERT_IMPL(a_res_room, clk, rst, res_push, !res_full, "result written into full queue")
  `BDA_ASSERT_IMPL(a_div_free, clk, rst, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `BDA_ASSERT_NEXT(a_item_start, clk, rst, cmd_pop, state == S_EXEC, "popped item not started")
  `BDA_ASSERT_IMPL(a_one_edge, clk, rst, res_push, !(down && up), "down and up in one result")

endmodule

FILE: src/bda_resq.sv
module bda_resq #(
  parameter int DEPTH = bda_pkg::RES_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_push,
  input  bda_pkg::out_t res,
  output logic          res_full,
  output logic          empty,
  input  logic          pop,
  output bda_pkg::out_t result
);
  import bda_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign res_full = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign result   = slots[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/button_debounce_autorepeat.sv
// Button debouncer with auto-repeat. Each poll pushed in carries the raw pin
// level, a free-running 32-bit microsecond timestamp and a take flag; each
// poll yields exactly one result, in order, holding the down and up pulses,
// the held level, the last and current press durations and, when take is
// set, the repeat count, which is then cleared. Polls wait in an input queue
// of CMD_DEPTH entries and results in an output queue of RES_DEPTH entries,
// so both sides may stall on their own. A poll goes through idle, exec and
// finish in the released and debounce states, plus hold when pressed; in the
// repeat state each pass over the repeat stamp adds a sum and a compare state,
// and a pass that owes repeats adds a restoring divide, with at most 64 passes
// per poll. The time settings are written in milliseconds and held in
// microseconds; write them only while no poll is in flight.
module button_debounce_autorepeat #(
  parameter int CMD_DEPTH = bda_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH = bda_pkg::RES_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  bda_pkg::in_t                    item,
  output logic                            empty,
  input  logic                            pop,
  output bda_pkg::out_t                   result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bda_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bda_pkg::MS_W-1:0]        cfg_data
);
  import bda_pkg::*;

  logic            invert;
  logic [US_W-1:0] debounce_us;
  logic [US_W-1:0] delay_us;
  logic [US_W-1:0] step_us;
  logic [US_W-1:0] data_us;
  logic            cmd_valid;
  cmd_t            cmd;
  logic            cmd_pop;
  logic            res_push;
  out_t            res;
  logic            res_full;

  assign cfg_ready = 1'b1;
  assign data_us   = US_W'(cfg_data * US_PER_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      invert      <= 1'b0;
      debounce_us <= '0;
      delay_us    <= '0;
      step_us     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INVERT:   invert      <= cfg_data[0];
        CFG_DEBOUNCE: debounce_us <= data_us;
        CFG_DELAY:    delay_us    <= data_us;
        CFG_INTERVAL: step_us     <= data_us;
        default:      invert      <= invert;
      endcase
    end
  end

  bda_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .invert    (invert),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  bda_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .debounce_us (debounce_us),
    .delay_us    (delay_us),
    .step_us     (step_us),
    .res_push    (res_push),
    .res         (res),
    .res_full    (res_full)
  );

  bda_resq #(
    .DEPTH (RES_DEPTH)
  ) u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_POLLS = 2000;

  typedef enum logic [1:0] {
    MODE_RELEASED,
    MODE_DEBOUNCE,
    MODE_PRESSED,
    MODE_REPEAT
  } mode_e;

  class press_scoreboard;
    bit          invert;
    bit [15:0]   settle_ms;
    bit [15:0]   delay_ms;
    bit [15:0]   interval_ms;
    mode_e       mode;
    bit [31:0]   start_stamp;
    bit [31:0]   last_len;
    bit [31:0]   repeat_stamp;
    bit [15:0]   tally;
    out_t        expected_q[$];
    int          errors;
    int          polls;
    int          downs;
    int          ups;
    int          saturations;
    int          wrap_stops;

    function new();
      invert = 0;
      settle_ms = 0;
      delay_ms = 0;
      interval_ms = 0;
      mode = MODE_RELEASED;
      start_stamp = 0;
      last_len = 0;
      repeat_stamp = 0;
      tally = 0;
      errors = 0;
      polls = 0;
      downs = 0;
      ups = 0;
      saturations = 0;
      wrap_stops = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [MS_W-1:0] data);
      case (idx)
        CFG_INVERT:   invert = data[0];
        CFG_DEBOUNCE: settle_ms = data;
        CFG_DELAY:    delay_ms = data;
        CFG_INTERVAL: interval_ms = data;
        default: ;
      endcase
    endfunction

    function void add_repeats(bit [63:0] k);
      bit [63:0] t;
      t = 64'(tally) + k;
      if (t > 64'(TALLY_MAX)) begin
        tally = TALLY_MAX;
        saturations++;
      end else begin
        tally = t[15:0];
      end
    endfunction

    // count the intervals owed since the last repeat, one wrap at a time
    function void catch_up(bit [31:0] now);
      bit [31:0] step;
      bit [31:0] s;
      bit [31:0] diff;
      bit [63:0] k;
      step = 32'(interval_ms) * 32'(US_PER_MS);
      for (int n = 0; n < WRAP_LIMIT; n++) begin
        s = repeat_stamp + step;
        if (s >= now) return;
        diff = now - s;
        k = (64'(diff) + 64'(step) - 64'd1) / 64'(step);
        add_repeats(k);
        repeat_stamp = 32'(64'(s) + (k - 64'd1) * 64'(step));
      end
      wrap_stops++;
    endfunction

    function void note_poll(in_t p);
      out_t      o;
      bit        pressed;
      bit [31:0] lim;
      o = '0;
      pressed = p.pin_level ^ invert;
      case (mode)
        MODE_RELEASED: begin
          if (pressed) begin
            mode = MODE_DEBOUNCE;
            start_stamp = p.now_us;
          end
        end
        MODE_DEBOUNCE: begin
          if (pressed) begin
            lim = start_stamp + 32'(settle_ms) * 32'(US_PER_MS);
            if (p.now_us >= lim) begin
              o.went_down = 1'b1;
              mode = MODE_PRESSED;
              start_stamp = p.now_us;
              tally = 16'd1;
              downs++;
            end
          end else begin
            mode = MODE_RELEASED;
          end
        end
        default: begin
          if (mode == MODE_REPEAT && interval_ms != 0) catch_up(p.now_us);
          o.held = pressed;
          if (pressed) begin
            lim = start_stamp + 32'(delay_ms) * 32'(US_PER_MS);
            if (mode == MODE_PRESSED && delay_ms != 0 && p.now_us >= lim) begin
              mode = MODE_REPEAT;
              repeat_stamp = p.now_us;
              add_repeats(64'd1);
            end
          end else begin
            o.went_up = 1'b1;
            mode = MODE_RELEASED;
            last_len = p.now_us - start_stamp;
            ups++;
          end
        end
      endcase
      if (p.take_repeats) begin
        o.repeat_total = tally;
        tally = 0;
      end
      o.last_press_us = last_len;
      o.current_press_us = p.now_us - start_stamp;
      expected_q.push_back(o);
      polls++;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_t r);
      out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, r);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("went_down", 32'(e.went_down), 32'(r.went_down));
      compare_field("went_up", 32'(e.went_up), 32'(r.went_up));
      compare_field("held", 32'(e.held), 32'(r.held));
      compare_field("last_press_us", e.last_press_us, r.last_press_us);
      compare_field("current_press_us", e.current_press_us, r.current_press_us);
      compare_field("repeat_total", 32'(e.repeat_total), 32'(r.repeat_total));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  in_t                    item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  out_t                   result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]        cfg_data = '0;

  press_scoreboard sb = new();

  int unsigned cycles = 0;
  int          polls_sent = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          cfg_inv = 1'b0;
  int unsigned time_unit = 1000;
  logic [31:0] now_cur = '0;
  int          settings_used = 0;
  int          stall_style = 0;
  int unsigned stall_cnt = 0;

  always #1 clk = ~clk;

  button_debounce_autorepeat uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt % 300 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: pop = 1'b1;
      1: pop = 1'($urandom_range(0, 1));
      2: pop = (stall_cnt % 8 == 0);
      default: pop = ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(result);
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [MS_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    push = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic configure(bit inv, logic [15:0] db, logic [15:0] dl, logic [15:0] iv);
    int unsigned m;
    drain();
    write_reg(CFG_INVERT, {15'd0, inv});
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_DELAY, dl);
    write_reg(CFG_INTERVAL, iv);
    cfg_inv = inv;
    m = (db > iv) ? db : iv;
    time_unit = (m + dl / 8 + 1) * 500;
    settings_used++;
  endtask

  task automatic send_poll(logic pin, logic [31:0] now, logic take);
    in_t p;
    p.pin_level = pin;
    p.now_us = now;
    p.take_repeats = take;
    if (burst_left == 0) begin
      if (gaps_on) begin
        push = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push = 1'b1;
    item = p;
    do @(posedge clk); while (full);
    sb.note_poll(p);
    polls_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  function automatic logic [31:0] next_now();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) now_cur += $urandom_range(0, time_unit);
    else if (pick < 90) now_cur += $urandom_range(0, 4 * time_unit);
    else if (pick >= 95) now_cur = $urandom;
    return now_cur;
  endfunction

  function automatic logic want_take();
    return ($urandom_range(0, 3) == 0);
  endfunction

  // debounce 1 ms, delay 2 ms, interval 1 ms
  task automatic run_directed();
    send_poll(1'b1, 32'd0, 1'b0);
    send_poll(1'b1, 32'd500, 1'b0);
    send_poll(1'b0, 32'd600, 1'b0);
    send_poll(1'b1, 32'd700, 1'b0);
    send_poll(1'b1, 32'd1700, 1'b1);
    send_poll(1'b1, 32'd2000, 1'b0);
    send_poll(1'b1, 32'd3700, 1'b0);
    send_poll(1'b1, 32'd9000, 1'b1);
    send_poll(1'b0, 32'd9100, 1'b0);
    send_poll(1'b0, 32'hFFFF_FFFF, 1'b1);
    send_poll(1'b1, 32'hFFFF_FC00, 1'b0);
    send_poll(1'b1, 32'h0000_0100, 1'b0);
    send_poll(1'b1, 32'hFFFF_FFF0, 1'b0);
    send_poll(1'b1, 32'h0000_0800, 1'b0);
    send_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_poll(1'b1, 32'h0000_0000, 1'b1);
    send_poll(1'b0, 32'h0000_0010, 1'b0);
    send_poll(1'b1, 32'hFFFF_FFFF, 1'b0);
    send_poll(1'b0, 32'h0000_0000, 1'b1);
  endtask

  task automatic run_random(int count);
    int target;
    int len;
    int r;
    target = polls_sent + count;
    now_cur = $urandom;
    while (polls_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 3) drain();
      if (r < 80) begin
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) send_poll(cfg_inv, next_now(), want_take());
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) send_poll(cfg_inv, next_now(), want_take());
          else send_poll(~cfg_inv, next_now(), want_take());
        end
        send_poll(cfg_inv, next_now(), want_take());
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_poll(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;

    configure(1'b0, 16'd1, 16'd2, 16'd1);
    run_directed();

    configure(1'b1, 16'd0, 16'd0, 16'd0);
    run_random(RANDOM_POLLS / 7);
    gaps_on = 1'b0;
    configure(1'b0, 16'd3, 16'd20, 16'd2);
    run_random(RANDOM_POLLS / 7);
    gaps_on = 1'b1;
    configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(RANDOM_POLLS / 7);
    configure(1'b0, 16'd2, 16'd5, 16'd0);
    run_random(RANDOM_POLLS / 7);
    configure(1'b1, 16'd1, 16'd1, 16'd1);
    run_random(RANDOM_POLLS / 7);
    gaps_on = 1'b0;
    configure(1'b0, 16'($urandom_range(0, 50)), 16'($urandom_range(0, 100)),
              16'($urandom_range(0, 20)));
    run_random(RANDOM_POLLS / 7);
    gaps_on = 1'b1;
    configure(1'($urandom_range(0, 1)), 16'($urandom_range(0, 10)),
              16'($urandom_range(1, 30)), 16'($urandom_range(1, 5)));
    run_random(RANDOM_POLLS / 7);

    push = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("covered %0d polls over %0d settings: %0d presses, %0d releases",
             sb.polls, settings_used, sb.downs, sb.ups);
    $display("%0d tally saturations, %0d catch-ups cut at the wrap limit, %0d mismatches",
             sb.saturations, sb.wrap_stops, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bda_pkg.sv
src/bda_front.sv
src/bda_div.sv
src/bda_back.sv
src/bda_resq.sv
src/button_debounce_autorepeat.sv
verif/tb.sv
